// ===== hdl/rmvci_pkg.sv =====
// ----------------------------------------------------------------------------
// rmvci_pkg
// Shared types and constants of the running mean / variance / interval unit.
// ----------------------------------------------------------------------------
package rmvci_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  // Widest divisor is (n-1)*n.
  localparam int DVS_W       = 2 * CNT_W;
  localparam int TCRIT_W     = 24;
  localparam logic [TCRIT_W-1:0] TCRIT_RESET = 24'd166396;
  localparam int ADDR_W      = 3;
  localparam logic [ADDR_W-3:0] REG_T_CRITICAL = 1'b0;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [47:0]        variance;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [10:0]        count;
    logic               too_few_samples;
  } out_data_t;

  typedef struct packed {
    logic             start;
    logic [63:0]      dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/rmvci_div.sv =====
// ----------------------------------------------------------------------------
// rmvci_div
// Restoring unsigned divider, 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvci_div import rmvci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot
);

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [63:0]      quo_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem_r, quo_r[63]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hdl/rmvci_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmvci_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rmvci_isqrt import rmvci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (v_r >= sum) begin
          v_r   <= v_r - sum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        v_r    <= value;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        busy_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// ===== hdl/running_mean_variance_conf_interval_unit.sv =====
// ----------------------------------------------------------------------------
// running_mean_variance_conf_interval_unit
// Welford running mean and variance with a Student-t confidence interval.
// ----------------------------------------------------------------------------
// Samples arrive on the in_ channel (valid/ready), one Q16.16 value per beat.
// A beat that carries last closes the set: one result beat with mean,
// variance, interval bounds and count goes out on the out_ channel, and the
// accumulators are cleared. t_critical is written over the cfg_ APB port.
// Each sample takes one multiply and two divisions by the count, the
// divisions on the single shared bit-serial divider. With two or more
// samples, a last sample adds two more divisions, a square root and two
// multiplies. in_ready is high only while the sequencer is idle.
// Once a full set is held, further samples are taken but not accumulated.
// A result waits in the output register while out_ready is low; the next
// set's samples are still taken, and only a following result waits for it.
// Synchronous reset clears the accumulators and the output valid flag and
// sets t_critical to its default of 2.539.
// ----------------------------------------------------------------------------
module running_mean_variance_conf_interval_unit import rmvci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_data_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_data_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_D1GO, S_D1, S_D2GO, S_D2, S_NN, S_D3GO, S_D3,
    S_D4GO, S_D4, S_RTGO, S_RT, S_MULH, S_DONE
  } state_t;

  state_t             state_r;
  logic [TCRIT_W-1:0] tcrit_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   n_r;
  logic signed [47:0] mean_r;
  logic [63:0]        sdsum_r;
  logic               last_r;
  logic               neg_r;
  logic [48:0]        mag_r;
  logic [31:0]        q_r;
  logic [63:0]        prod_r;
  logic [63:0]        quot_r;
  logic [47:0]        var_r;
  logic [31:0]        root_r;
  logic               out_valid_r;
  out_data_t          out_r;

  logic signed [48:0] diff;
  logic [48:0]        mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [64:0]        sd_sum;
  logic [63:0]        term;
  logic signed [48:0] mean_sum;
  logic [48:0]        step_mag;
  logic               few;
  logic [39:0]        half;
  logic signed [41:0] m16;
  logic signed [41:0] lo;
  logic signed [41:0] hi;
  logic [CNT_W-1:0]   cnt_m1;
  div_req_t           div_req;
  logic               div_done;
  logic [63:0]        div_quot;
  logic               rt_done;
  logic [31:0]        rt_root;
  logic               cfg_wr;

  // Deviation of the new sample from the running mean, Q16.32.
  assign diff = 49'($signed({in_data.sample, 16'b0})) - 49'(mean_r);
  assign mag  = diff[48] ? 49'(-diff) : diff;

  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    case (state_r)
      S_NN: begin
        mul_a = 32'(cnt_m1);
        mul_b = 32'(count_r);
      end
      S_MULH: begin
        mul_a = root_r;
        mul_b = 32'(tcrit_r);
      end
      default: begin
        mul_a = q_r;
        mul_b = q_r;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = DVS_W'(n_r);
    case (state_r)
      S_D1GO: div_req.start = 1'b1;
      S_D2GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(mag_r);
      end
      S_D3GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sdsum_r;
        div_req.divisor  = prod_r[DVS_W-1:0];
      end
      S_D4GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sdsum_r;
        div_req.divisor  = DVS_W'(cnt_m1);
      end
      default: ;
    endcase
  end

  rmvci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  rmvci_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_RTGO),
    .value (quot_r),
    .done  (rt_done),
    .root  (rt_root)
  );

  assign term     = prod_r - div_quot;
  assign sd_sum   = {1'b0, sdsum_r} + {1'b0, term};
  assign step_mag = div_quot[48:0];
  assign mean_sum = 49'(mean_r) + (neg_r ? 49'(-step_mag) : step_mag);

  assign few  = count_r < CNT_W'(2);
  assign half = few ? 40'd0 : prod_r[55:16];
  assign m16  = 42'($signed(mean_r[47:16]));
  assign lo   = m16 - 42'(half);
  assign hi   = m16 + 42'(half);

  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647)       return 32'h7FFF_FFFF;
    else if (v < -42'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tcrit_r     <= TCRIT_RESET;
      count_r     <= '0;
      mean_r      <= '0;
      sdsum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[ADDR_W-1:2] == REG_T_CRITICAL) begin
        tcrit_r <= cfg_pwdata[TCRIT_W-1:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_data.last;
            neg_r  <= diff[48];
            mag_r  <= mag;
            q_r    <= mag[47:16];
            n_r    <= count_r + CNT_W'(1);
            if (count_r < CNT_W'(MAX_SAMPLES)) begin
              state_r <= S_SQ;
            end else if (in_data.last) begin
              state_r <= S_NN;
            end
          end
        end
        S_SQ: begin
          prod_r  <= mul_p;
          state_r <= S_D1GO;
        end
        S_D1GO: state_r <= S_D1;
        S_D1: begin
          if (div_done) begin
            sdsum_r <= sd_sum[64] ? '1 : sd_sum[63:0];
            state_r <= S_D2GO;
          end
        end
        S_D2GO: state_r <= S_D2;
        S_D2: begin
          if (div_done) begin
            mean_r  <= mean_sum[47:0];
            count_r <= n_r;
            state_r <= last_r ? S_NN : S_IDLE;
          end
        end
        S_NN: begin
          prod_r  <= mul_p;
          state_r <= few ? S_DONE : S_D3GO;
        end
        S_D3GO: state_r <= S_D3;
        S_D3: begin
          if (div_done) begin
            quot_r  <= div_quot;
            state_r <= S_D4GO;
          end
        end
        S_D4GO: state_r <= S_D4;
        S_D4: begin
          if (div_done) begin
            var_r   <= div_quot[63:16];
            state_r <= S_RTGO;
          end
        end
        S_RTGO: state_r <= S_RT;
        S_RT: begin
          if (rt_done) begin
            root_r  <= rt_root;
            state_r <= S_MULH;
          end
        end
        S_MULH: begin
          prod_r  <= mul_p;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free or is being emptied.
          if (!out_valid_r || out_ready) begin
            out_r.mean            <= m16[31:0];
            out_r.variance        <= few ? 48'd0 : var_r;
            out_r.lower_bound     <= sat32(lo);
            out_r.upper_bound     <= sat32(hi);
            out_r.count           <= 11'(count_r);
            out_r.too_few_samples <= few;
            out_valid_r           <= 1'b1;
            count_r               <= '0;
            mean_r                <= '0;
            sdsum_r               <= '0;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[ADDR_W-1:2] == REG_T_CRITICAL) ? 32'(tcrit_r) : 32'd0;

  a_few_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.too_few_samples == (out_data.count < 11'd2)))
    else $error("too_few_samples does not match count");

  a_few_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_few_samples |->
      out_data.variance == 48'd0 && out_data.lower_bound == out_data.mean &&
      out_data.upper_bound == out_data.mean)
    else $error("short set must give zero variance and zero half-width");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lower_bound <= out_data.upper_bound)
    else $error("interval bounds out of order");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ready) |=> count_r == '0 && sdsum_r == '0)
    else $error("accumulators not cleared after a result");

endmodule

// ===== tb/running_mean_variance_conf_interval_unit_tb.sv =====
// ----------------------------------------------------------------------------
// running_mean_variance_conf_interval_unit_tb
// Self-checking bench for the running mean / variance / interval unit.
// ----------------------------------------------------------------------------
// Sample beats are fed from a queue by a clocked driver. A built-in predictor
// keeps its own count, Welford mean and squared-deviation sum and works out
// the result of every set. Result beats are checked field by field. Phases
// change t_critical and the idle and stall rates of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_mean_variance_conf_interval_unit_tb;
  import rmvci_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_data_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_data_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  running_mean_variance_conf_interval_unit uut (.*);

  always #10 clk = ~clk;

  // Predictor state.
  int unsigned     set_count;
  longint          mean_q16_32;
  bit [63:0]       dev_sum;
  bit [23:0]       t_crit;

  in_data_t        sample_queue[$];
  out_data_t       result_queue[$];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              errors;
  int              quiet_cycles;
  bit              in_beat;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic predict_sample(input in_data_t b);
    longint      x;
    longint      diff;
    longint      m16;
    longint      half;
    bit [63:0]   mag;
    bit [63:0]   sq;
    bit [63:0]   term;
    bit [63:0]   nn;
    bit [63:0]   var_full;
    int unsigned n;
    out_data_t   r;
    if (set_count < MAX_SAMPLES) begin
      n = set_count + 1;
      x = longint'(b.sample) * 64'sd65536;
      diff = x - mean_q16_32;
      mag = (diff < 0) ? -diff : diff;
      sq = (mag >> 16) * (mag >> 16);
      term = sq - sq / n;
      if (dev_sum > 64'hFFFF_FFFF_FFFF_FFFF - term) dev_sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else dev_sum = dev_sum + term;
      mean_q16_32 = mean_q16_32 + diff / longint'(n);
      set_count = n;
    end
    if (!b.last) return;
    nn = set_count;
    m16 = mean_q16_32 >>> 16;
    half = 0;
    var_full = '0;
    r.too_few_samples = (nn < 2);
    if (nn >= 2) begin
      var_full = (dev_sum / (nn - 1)) >> 16;
      half = longint'((int_sqrt(dev_sum / ((nn - 1) * nn)) * t_crit) >> 16);
    end
    r.mean = clamp32(m16);
    r.variance = var_full[47:0];
    r.lower_bound = clamp32(m16 - half);
    r.upper_bound = clamp32(m16 + half);
    r.count = nn[10:0];
    result_queue.push_back(r);
    set_count = 0;
    mean_q16_32 = 0;
    dev_sum = '0;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: accepted beats are sampled at the rising edge.
  always @(posedge clk) begin
    out_data_t e;
    in_beat = rst_n && in_valid && in_ready;
    if (in_beat) predict_sample(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $error("result beat with no result expected");
        errors++;
      end else begin
        e = result_queue.pop_front();
        check_field("mean", e.mean, out_data.mean);
        check_field("variance", e.variance, out_data.variance);
        check_field("lower_bound", e.lower_bound, out_data.lower_bound);
        check_field("upper_bound", e.upper_bound, out_data.upper_bound);
        check_field("count", e.count, out_data.count);
        check_field("too_few_samples", e.too_few_samples, out_data.too_few_samples);
      end
    end
    if (in_beat || (out_valid && out_ready) || !(in_valid || result_queue.size() > 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: inputs change at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_beat) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_t_crit(input logic [23:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_T_CRITICAL, 2'b00};
    cfg_pwdata <= {8'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    t_crit = value;
  endtask

  function automatic in_data_t beat(input logic [31:0] s, input logic l);
    in_data_t b;
    b.sample = s;
    b.last = l;
    return b;
  endfunction

  // Waits until the unit has taken every sample and delivered every result.
  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_valid || result_queue.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_sample(input logic [31:0] base);
    case ($urandom_range(9))
      0: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return ($urandom_range(1)) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      2, 3, 4, 5: return base + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_sets(input int items);
    int          queued;
    int          len;
    logic [31:0] base;
    queued = 0;
    while (queued < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      base = ($urandom_range(1)) ? $urandom : $urandom_range(32'h0010_0000) - 32'h0008_0000;
      for (int i = 0; i < len; i++)
        sample_queue.push_back(beat(pick_sample(base), i == len - 1));
      queued += len;
      // Now and then hold off until the unit has caught up.
      if ($urandom_range(15) == 0) wait_idle();
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [23:0] tc, input int items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_t_crit(tc);
    queue_random_sets(items);
    wait_idle();
  endtask

  initial begin
    set_count = 0;
    mean_q16_32 = 0;
    dev_sum = '0;
    t_crit = TCRIT_RESET;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets at the reset value of t_critical.
    sample_queue.push_back(beat(32'h0001_8000, 1'b1));
    sample_queue.push_back(beat(32'h0001_0000, 1'b0));
    sample_queue.push_back(beat(32'h0003_0000, 1'b1));
    sample_queue.push_back(beat(32'h0000_0000, 1'b0));
    sample_queue.push_back(beat(32'h0000_0000, 1'b1));
    sample_queue.push_back(beat(32'hFFFF_FFFF, 1'b0));
    sample_queue.push_back(beat(32'hFFFF_FFFE, 1'b0));
    sample_queue.push_back(beat(32'hFFFF_FFFD, 1'b1));
    sample_queue.push_back(beat(32'h8000_0000, 1'b1));
    // Alternating extremes drive the deviation sum into saturation.
    for (int i = 0; i < 10; i++)
      sample_queue.push_back(beat(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, i == 9));
    sample_queue.push_back(beat(32'h7FFF_FFFF, 1'b0));
    sample_queue.push_back(beat(32'h7FFF_FFFF, 1'b1));
    wait_idle();

    // A set that overruns the sample limit; the extra beats are not counted.
    for (int i = 0; i < MAX_SAMPLES + 6; i++)
      sample_queue.push_back(beat($urandom_range(32'h0020_0000) - 32'h0010_0000,
                                  i == MAX_SAMPLES + 5));
    wait_idle();

    run_phase(0, 0, 24'd0, 160);
    run_phase(57, 0, 24'hFF_FFFF, 160);
    run_phase(0, 57, TCRIT_RESET, 160);
    run_phase(6, 6, $urandom_range(24'hFF_FFFF), 170);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
